// ----- hdl/ycr_pkg.sv -----
package ycr_pkg;

	// Configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 13;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEFT   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TOP    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_WIDTH  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HEIGHT = 3'd5;

	// BT.601 full-range coefficients, 16 fractional bits
	localparam logic signed [17:0] COEF_RV = 18'sd91947;
	localparam logic signed [17:0] COEF_GU = 18'sd22544;
	localparam logic signed [17:0] COEF_GV = 18'sd46793;
	localparam logic signed [17:0] COEF_BU = 18'sd115999;
	localparam logic signed [8:0]  CHROMA_BIAS = 9'sd128;

	typedef logic [7:0] sample_t;

	// Floored chroma contribution to one channel, range about -227..224
	typedef logic signed [9:0] chroma_off_t;

	typedef struct packed {
		logic [12:0] frame_width;
		logic [12:0] frame_height;
		logic [11:0] window_left;
		logic [11:0] window_top;
		logic [12:0] window_width;
		logic [12:0] window_height;
	} cfg_t;

	typedef struct packed {
		logic in_window;
		logic row_end;
		logic window_end;
	} pos_flags_t;

endpackage

// ----- hdl/ycr_if.sv -----
interface ycr_yuyv_if;
	logic             valid;
	logic             ready;
	ycr_pkg::sample_t luma_first;
	ycr_pkg::sample_t chroma_blue;
	ycr_pkg::sample_t luma_second;
	ycr_pkg::sample_t chroma_red;
	logic             frame_start;

	modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
		frame_start, input ready);
	modport sink (input valid, luma_first, chroma_blue, luma_second, chroma_red,
		frame_start, output ready);
endinterface

interface ycr_rgb_if;
	logic             valid;
	logic             ready;
	ycr_pkg::sample_t red_first;
	ycr_pkg::sample_t green_first;
	ycr_pkg::sample_t blue_first;
	ycr_pkg::sample_t red_second;
	ycr_pkg::sample_t green_second;
	ycr_pkg::sample_t blue_second;
	logic             row_end;
	logic             window_end;

	modport source (output valid, red_first, green_first, blue_first, red_second,
		green_second, blue_second, row_end, window_end, input ready);
	modport sink (input valid, red_first, green_first, blue_first, red_second,
		green_second, blue_second, row_end, window_end, output ready);
endinterface

interface ycr_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [ycr_pkg::CFG_INDEX_W-1:0]    reg_index;
	logic [ycr_pkg::CFG_DATA_W-1:0]     wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// ----- hdl/ycr_pos.sv -----
module ycr_pos #(
	parameter int MaxWidth  = 4096,
	parameter int MaxHeight = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ycr_pkg::cfg_t       cfg,
	input  logic                advance,
	input  logic                frame_start,
	output ycr_pkg::pos_flags_t flags
);

	localparam int MaxWEven = MaxWidth - (MaxWidth % 2);
	localparam int MaxWClip = (MaxWEven < 2) ? 2 : MaxWEven;
	localparam logic [14:0] MaxW = 15'(MaxWClip);
	localparam logic [14:0] MaxH = 15'(MaxHeight);

	logic [12:0] col_q, row_q;
	logic [14:0] fw_raw, fw_sat, fh_raw, fh_sat;
	logic [13:0] fw, fh, left, top, right, bottom, right_raw, bottom_raw;
	logic [13:0] col_e, row_e, col_n, row_n;
	logic        last_in_row;

	always_comb begin
		fw_raw = {2'b00, cfg.frame_width[12:1], 1'b0};
		fw_sat = (fw_raw > MaxW) ? MaxW : fw_raw;
		if (fw_sat < 15'd2) begin
			fw_sat = 15'd2;
		end
		fw = fw_sat[13:0];

		fh_raw = {2'b00, cfg.frame_height};
		fh_sat = (fh_raw > MaxH) ? MaxH : fh_raw;
		if (fh_sat == 15'd0) begin
			fh_sat = 15'd1;
		end
		fh = fh_sat[13:0];

		left       = {2'b00, cfg.window_left[11:1], 1'b0};
		top        = {2'b00, cfg.window_top};
		right_raw  = left + {1'b0, cfg.window_width[12:1], 1'b0};
		right      = (right_raw > fw) ? fw : right_raw;
		bottom_raw = top + {1'b0, cfg.window_height};
		bottom     = (bottom_raw > fh) ? fh : bottom_raw;

		// wrap a stale position left behind by a smaller frame
		if (frame_start) begin
			col_e = '0;
			row_e = '0;
		end else begin
			col_e = {1'b0, col_q};
			row_e = {1'b0, row_q};
			if (col_e >= fw) begin
				col_e = '0;
				row_e = row_e + 14'd1;
			end
			if (row_e >= fh) begin
				row_e = '0;
			end
		end

		last_in_row      = (col_e + 14'd2) >= right;
		flags.in_window  = (col_e >= left) && (col_e < right) &&
			(row_e >= top) && (row_e < bottom);
		flags.row_end    = last_in_row;
		flags.window_end = last_in_row && ((row_e + 14'd1) >= bottom);

		col_n = col_e + 14'd2;
		row_n = row_e;
		if (col_n >= fw) begin
			col_n = '0;
			row_n = row_e + 14'd1;
			if (row_n >= fh) begin
				row_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			col_q <= col_n[12:0];
			row_q <= row_n[12:0];
		end
	end

endmodule

// ----- hdl/ycr_chroma.sv -----
module ycr_chroma (
	input  logic                 clk,
	input  logic                 adv_s1,
	input  logic                 adv_s2,
	input  ycr_pkg::sample_t     chroma_blue,
	input  ycr_pkg::sample_t     chroma_red,
	output ycr_pkg::chroma_off_t r_off_s2,
	output ycr_pkg::chroma_off_t g_off_s2,
	output ycr_pkg::chroma_off_t b_off_s2
);

	logic signed [8:0]  uu, vv;
	logic signed [26:0] rv_s1, gu_s1, gv_s1, bu_s1;
	logic signed [27:0] g_sum;

	assign uu    = $signed({1'b0, chroma_blue}) - ycr_pkg::CHROMA_BIAS;
	assign vv    = $signed({1'b0, chroma_red}) - ycr_pkg::CHROMA_BIAS;
	assign g_sum = 28'(gu_s1) + 28'(gv_s1);

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rv_s1 <= 27'(vv) * 27'(ycr_pkg::COEF_RV);
			gu_s1 <= 27'(uu) * 27'(ycr_pkg::COEF_GU);
			gv_s1 <= 27'(vv) * 27'(ycr_pkg::COEF_GV);
			bu_s1 <= 27'(uu) * 27'(ycr_pkg::COEF_BU);
		end
	end

	// bits above the fraction give the floor of an arithmetic shift by 16
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			r_off_s2 <= rv_s1[25:16];
			g_off_s2 <= g_sum[25:16];
			b_off_s2 <= bu_s1[25:16];
		end
	end

endmodule

// ----- hdl/ycr_lane.sv -----
module ycr_lane (
	input  logic                 clk,
	input  logic                 adv_s3,
	input  ycr_pkg::sample_t     luma_s2,
	input  ycr_pkg::chroma_off_t r_off_s2,
	input  ycr_pkg::chroma_off_t g_off_s2,
	input  ycr_pkg::chroma_off_t b_off_s2,
	output ycr_pkg::sample_t     red_s3,
	output ycr_pkg::sample_t     green_s3,
	output ycr_pkg::sample_t     blue_s3
);

	logic signed [10:0] y_ext, r_sum, g_sum, b_sum;

	function automatic ycr_pkg::sample_t clamp8(input logic signed [10:0] s);
		ycr_pkg::sample_t c;
		if (s[10]) begin
			c = 8'd0;
		end else if (|s[9:8]) begin
			c = 8'd255;
		end else begin
			c = s[7:0];
		end
		return c;
	endfunction

	assign y_ext = $signed({3'b000, luma_s2});
	assign r_sum = y_ext + 11'(r_off_s2);
	assign g_sum = y_ext - 11'(g_off_s2);
	assign b_sum = y_ext + 11'(b_off_s2);

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			red_s3   <= clamp8(r_sum);
			green_s3 <= clamp8(g_sum);
			blue_s3  <= clamp8(b_sum);
		end
	end

endmodule

// ----- hdl/yuyv_crop_to_rgb.sv -----
// Pipeline: an accepted macropixel beat has its chroma products registered at the accept
// edge, then its chroma sums, then its added and clamped RGB pair in the output register.
// Throughput: one macropixel per cycle unless rgb.ready stalls the output; beats outside
// the crop window give nothing. The three stages, ending in the output register, set this.
// Reset (arst_n low, asynchronous): position to column 0 of row 0, pipeline empty,
// registers back to a 640x480 frame with a full-frame window.
module yuyv_crop_to_rgb #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input logic          clk,
	input logic          arst_n,
	ycr_cfg_if.sink      cfg,
	ycr_yuyv_if.sink     yuyv,
	ycr_rgb_if.source    rgb
);

	ycr_pkg::cfg_t       cfg_q;
	ycr_pkg::pos_flags_t flags;
	logic                accept;
	logic                adv_s1, adv_s2, adv_s3;
	logic                valid_s1, valid_s2, valid_s3;
	ycr_pkg::sample_t    luma0_s1, luma1_s1, luma0_s2, luma1_s2;
	logic                row_end_s1, row_end_s2, row_end_s3;
	logic                win_end_s1, win_end_s2, win_end_s3;
	ycr_pkg::chroma_off_t r_off_s2, g_off_s2, b_off_s2;

	// Registers take a write every cycle; software must write them only while idle, which the block does not enforce.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width   <= 13'd640;
			cfg_q.frame_height  <= 13'd480;
			cfg_q.window_left   <= 12'd0;
			cfg_q.window_top    <= 12'd0;
			cfg_q.window_width  <= 13'd640;
			cfg_q.window_height <= 13'd480;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				ycr_pkg::REG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg.wr_data;
				ycr_pkg::REG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg.wr_data;
				ycr_pkg::REG_WINDOW_LEFT:   cfg_q.window_left   <= cfg.wr_data[11:0];
				ycr_pkg::REG_WINDOW_TOP:    cfg_q.window_top    <= cfg.wr_data[11:0];
				ycr_pkg::REG_WINDOW_WIDTH:  cfg_q.window_width  <= cfg.wr_data;
				ycr_pkg::REG_WINDOW_HEIGHT: cfg_q.window_height <= cfg.wr_data;
				default: begin
					// drop writes to unused indexes
				end
			endcase
		end
	end

	// Pipeline control: a stage advances when it is empty or the stage after it
	// advances. The output register is the last stage, so a waiting result still
	// lets new beats in as long as an earlier stage has room.
	assign adv_s3     = !valid_s3 || rgb.ready;
	assign adv_s2     = !valid_s2 || adv_s3;
	assign adv_s1     = !valid_s1 || adv_s2;
	assign yuyv.ready = adv_s1;
	assign accept     = yuyv.valid && adv_s1;

	// Raster position tracker and window test for the beat now at the input.
	ycr_pos #(
		.MaxWidth  (MAX_WIDTH),
		.MaxHeight (MAX_HEIGHT)
	) u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.advance     (accept),
		.frame_start (yuyv.frame_start),
		.flags       (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			// Beats outside the window leave no bubble-filling result behind.
			if (adv_s1) begin
				valid_s1 <= accept && flags.in_window;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Side data that rides along with the chroma pipeline.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			luma0_s1   <= yuyv.luma_first;
			luma1_s1   <= yuyv.luma_second;
			row_end_s1 <= flags.row_end;
			win_end_s1 <= flags.window_end;
		end
		if (adv_s2) begin
			luma0_s2   <= luma0_s1;
			luma1_s2   <= luma1_s1;
			row_end_s2 <= row_end_s1;
			win_end_s2 <= win_end_s1;
		end
		if (adv_s3) begin
			row_end_s3 <= row_end_s2;
			win_end_s3 <= win_end_s2;
		end
	end

	// Chroma terms are shared by both pixels of the macropixel.
	ycr_chroma u_chroma (
		.clk         (clk),
		.adv_s1      (adv_s1),
		.adv_s2      (adv_s2),
		.chroma_blue (yuyv.chroma_blue),
		.chroma_red  (yuyv.chroma_red),
		.r_off_s2    (r_off_s2),
		.g_off_s2    (g_off_s2),
		.b_off_s2    (b_off_s2)
	);

	// One lane per pixel: add luma, clamp, and hold in the output register.
	ycr_lane u_lane_first (
		.clk      (clk),
		.adv_s3   (adv_s3),
		.luma_s2  (luma0_s2),
		.r_off_s2 (r_off_s2),
		.g_off_s2 (g_off_s2),
		.b_off_s2 (b_off_s2),
		.red_s3   (rgb.red_first),
		.green_s3 (rgb.green_first),
		.blue_s3  (rgb.blue_first)
	);

	ycr_lane u_lane_second (
		.clk      (clk),
		.adv_s3   (adv_s3),
		.luma_s2  (luma1_s2),
		.r_off_s2 (r_off_s2),
		.g_off_s2 (g_off_s2),
		.b_off_s2 (b_off_s2),
		.red_s3   (rgb.red_second),
		.green_s3 (rgb.green_second),
		.blue_s3  (rgb.blue_second)
	);

	// Merge: the two lanes and the row/window marks form one output beat.
	assign rgb.valid      = valid_s3;
	assign rgb.row_end    = row_end_s3;
	assign rgb.window_end = win_end_s3;

endmodule
